// File: rtl/ttb_pkg.sv
// Shared types, constants and the microcode table for the tempo converter.
// Used by ttb_div, ttb_seq, ttb_dpath and tempo_to_ticks_and_bpm_top.
// No dependencies.
package ttb_pkg;

  localparam int QPM_W  = 16;
  localparam int TICK_W = 8;
  localparam int BPM_W  = 9;
  localparam int PROD_W = 24;
  localparam int DIV_W  = 16;
  localparam int PC_W   = 5;
  localparam int RES_W  = 5;

  // Decision thresholds and fixed results
  localparam logic [PROD_W-1:0] KEEP_LO      = 24'd792;
  localparam logic [PROD_W-1:0] KEEP_HI      = 24'd6144;
  localparam logic [QPM_W-1:0]  QPM_VSLOW    = 16'd26;
  localparam logic [QPM_W-1:0]  QPM_SLOW_END = 16'd33;
  localparam logic [QPM_W-1:0]  QPM_FAST     = 16'd6144;
  localparam logic [DIV_W-1:0]  NUM_LO       = 16'd791;
  localparam logic [DIV_W-1:0]  NUM_HI       = 16'd6143;
  localparam logic [DIV_W-1:0]  DIV_BASE     = 16'd24;
  localparam logic [TICK_W-1:0] SLOW_TICKS   = 8'd31;
  localparam logic [BPM_W-1:0]  VSLOW_BPM    = 9'd33;
  localparam logic [TICK_W-1:0] FAST_TICKS   = 8'd1;
  localparam logic [BPM_W-1:0]  FAST_BPM     = 9'd255;
  localparam logic [TICK_W-1:0] ROUND_ADD    = 8'd12;
  localparam logic [RES_W:0]    BASE2        = 6'd24;

  // Division by 24 as ((x >> 3) * 2731) >> 13, exact for every 16-bit x
  localparam int                RECIP_SH     = 13;
  localparam logic [11:0]       RECIP_3      = 12'd2731;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL,
    OP_DIV,
    OP_SET_KEEP,
    OP_SET_VSLOW,
    OP_SET_SLOW,
    OP_SET_FAST,
    OP_INIT_BEST,
    OP_SET_LAST,
    OP_SET_STEP,
    OP_SET_R,
    OP_SCAN,
    OP_SET_SRCH,
    OP_EMIT
  } uop_t;

  typedef enum logic [1:0] {M_TICKS, M_31, M_BEST} msel_t;
  typedef enum logic [1:0] {ADD_ZERO, ADD_TICKS, ADD_12} asel_t;
  typedef enum logic [1:0] {N_791, N_6143, N_PROD, N_QPM} nsel_t;
  typedef enum logic {D_24, D_QPM} dsel_t;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_KEEP,
    J_LT26,
    J_LT33,
    J_GE6144,
    J_KDONE,
    J_KMORE
  } cond_t;

  typedef struct packed {
    uop_t            op;
    msel_t           msel;
    asel_t           asel;
    nsel_t           nsel;
    dsel_t           dsel;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic go;
    logic keep;
    logic lt26;
    logic lt33;
    logic ge6144;
    logic kdone;
    logic kmore;
  } stat_t;

  // Program labels
  localparam logic [PC_W-1:0] L_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] L_LOOP  = 5'd15;
  localparam logic [PC_W-1:0] L_SCAN  = 5'd16;
  localparam logic [PC_W-1:0] L_SFIN  = 5'd17;
  localparam logic [PC_W-1:0] L_KEEP  = 5'd20;
  localparam logic [PC_W-1:0] L_VSLOW = 5'd23;
  localparam logic [PC_W-1:0] L_SLOW  = 5'd24;
  localparam logic [PC_W-1:0] L_FAST  = 5'd27;
  localparam logic [PC_W-1:0] L_EMIT  = 5'd28;

  // Doubled distance of a residue mod 24 from 12; bigger is nearer a beat
  function automatic logic [RES_W-1:0] score(input logic [RES_W-1:0] r);
    logic [RES_W:0] d;
    d = {r, 1'b0};
    if (d >= BASE2) return RES_W'(d - BASE2);
    else return RES_W'(BASE2 - d);
  endfunction

  function automatic ctrl_t cw(input uop_t op, input msel_t ms, input asel_t as,
                               input nsel_t ns, input dsel_t ds, input cond_t cd,
                               input logic [PC_W-1:0] tg);
    ctrl_t c;
    c.op     = op;
    c.msel   = ms;
    c.asel   = as;
    c.nsel   = ns;
    c.dsel   = ds;
    c.cond   = cd;
    c.target = tg;
    return c;
  endfunction

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      5'd0:  c = cw(OP_ACCEPT,    M_TICKS, ADD_ZERO,  N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd1:  c = cw(OP_MUL,       M_TICKS, ADD_TICKS, N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd2:  c = cw(OP_NOP,       M_TICKS, ADD_ZERO,  N_791,  D_24,  J_KEEP,   L_KEEP);
      5'd3:  c = cw(OP_NOP,       M_TICKS, ADD_ZERO,  N_791,  D_24,  J_LT26,   L_VSLOW);
      5'd4:  c = cw(OP_NOP,       M_TICKS, ADD_ZERO,  N_791,  D_24,  J_LT33,   L_SLOW);
      5'd5:  c = cw(OP_NOP,       M_TICKS, ADD_ZERO,  N_791,  D_24,  J_GE6144, L_FAST);
      5'd6:  c = cw(OP_DIV,       M_TICKS, ADD_ZERO,  N_791,  D_QPM, J_NEVER,  L_IDLE);
      5'd7:  c = cw(OP_INIT_BEST, M_TICKS, ADD_ZERO,  N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd8:  c = cw(OP_DIV,       M_TICKS, ADD_ZERO,  N_6143, D_QPM, J_NEVER,  L_IDLE);
      5'd9:  c = cw(OP_SET_LAST,  M_TICKS, ADD_ZERO,  N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd10: c = cw(OP_DIV,       M_TICKS, ADD_ZERO,  N_QPM,  D_24,  J_NEVER,  L_IDLE);
      5'd11: c = cw(OP_SET_STEP,  M_TICKS, ADD_ZERO,  N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd12: c = cw(OP_MUL,       M_BEST,  ADD_ZERO,  N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd13: c = cw(OP_DIV,       M_TICKS, ADD_ZERO,  N_PROD, D_24,  J_NEVER,  L_IDLE);
      5'd14: c = cw(OP_SET_R,     M_TICKS, ADD_ZERO,  N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd15: c = cw(OP_NOP,       M_TICKS, ADD_ZERO,  N_791,  D_24,  J_KDONE,  L_SFIN);
      5'd16: c = cw(OP_SCAN,      M_TICKS, ADD_ZERO,  N_791,  D_24,  J_KMORE,  L_SCAN);
      5'd17: c = cw(OP_MUL,       M_BEST,  ADD_12,    N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd18: c = cw(OP_DIV,       M_TICKS, ADD_ZERO,  N_PROD, D_24,  J_NEVER,  L_IDLE);
      5'd19: c = cw(OP_SET_SRCH,  M_TICKS, ADD_ZERO,  N_791,  D_24,  J_ALWAYS, L_EMIT);
      5'd20: c = cw(OP_MUL,       M_TICKS, ADD_ZERO,  N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd21: c = cw(OP_DIV,       M_TICKS, ADD_ZERO,  N_PROD, D_24,  J_NEVER,  L_IDLE);
      5'd22: c = cw(OP_SET_KEEP,  M_TICKS, ADD_ZERO,  N_791,  D_24,  J_ALWAYS, L_EMIT);
      5'd23: c = cw(OP_SET_VSLOW, M_TICKS, ADD_ZERO,  N_791,  D_24,  J_ALWAYS, L_EMIT);
      5'd24: c = cw(OP_MUL,       M_31,    ADD_ZERO,  N_791,  D_24,  J_NEVER,  L_IDLE);
      5'd25: c = cw(OP_DIV,       M_TICKS, ADD_ZERO,  N_PROD, D_24,  J_NEVER,  L_IDLE);
      5'd26: c = cw(OP_SET_SLOW,  M_TICKS, ADD_ZERO,  N_791,  D_24,  J_ALWAYS, L_EMIT);
      5'd27: c = cw(OP_SET_FAST,  M_TICKS, ADD_ZERO,  N_791,  D_24,  J_ALWAYS, L_EMIT);
      5'd28: c = cw(OP_EMIT,      M_TICKS, ADD_ZERO,  N_791,  D_24,  J_ALWAYS, L_IDLE);
      default: c = cw(OP_NOP,     M_TICKS, ADD_ZERO,  N_791,  D_24,  J_ALWAYS, L_IDLE);
    endcase
    return c;
  endfunction

endpackage

// File: rtl/ttb_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ttb_pkg for the operand width.
module ttb_div
  import ttb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo,
  output logic [DIV_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DIV_W:0]   sh;
  logic [DIV_W:0]   diff;
  logic             fits;

  assign sh   = {rem, quo[DIV_W-1]};
  assign diff = sh - {1'b0, den};
  assign fits = (sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= sh[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: rtl/ttb_seq.sv
// Step counter and microcode fetch: selects the next step from the jump condition.
// Depends on ttb_pkg for the control word, status and the program table.
module ttb_seq
  import ttb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc;
  logic            take;

  assign ctrl = ucode(pc);

  always_comb begin
    case (ctrl.cond)
      J_NEVER:  take = 1'b0;
      J_ALWAYS: take = 1'b1;
      J_KEEP:   take = stat.keep;
      J_LT26:   take = stat.lt26;
      J_LT33:   take = stat.lt33;
      J_GE6144: take = stat.ge6144;
      J_KDONE:  take = stat.kdone;
      J_KMORE:  take = stat.kmore;
      default:  take = 1'b0;
    endcase
  end

  // Advance only when the current step reports completion
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= L_IDLE;
    end else if (stat.go) begin
      pc <= take ? ctrl.target : pc + 1'b1;
    end
  end

endmodule

// File: rtl/ttb_dpath.sv
// Datapath: operand registers, multiplier, divider hookup, search state and result register.
// Depends on ttb_pkg; instantiated with ttb_div results from the top level.
module ttb_dpath
  import ttb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctrl,
  output stat_t             stat,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [QPM_W-1:0]  quarters_per_minute,
  input  logic [TICK_W-1:0] current_ticks,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [TICK_W-1:0] ticks_per_division,
  output logic [BPM_W-1:0]  beats_per_minute,
  output logic              div_start,
  output logic [DIV_W-1:0]  div_num,
  output logic [DIV_W-1:0]  div_den,
  input  logic              div_done,
  input  logic [DIV_W-1:0]  div_quo,
  input  logic [DIV_W-1:0]  div_rem
);

  logic [QPM_W-1:0]  qpm;
  logic [TICK_W-1:0] ticks;
  logic [PROD_W-1:0] prod;
  logic [TICK_W-1:0] best;
  logic [TICK_W-1:0] kcur;
  logic [TICK_W-1:0] last;
  logic [RES_W-1:0]  stp;
  logic [RES_W-1:0]  r;
  logic [RES_W-1:0]  bsc;
  logic [TICK_W-1:0] spd;
  logic [BPM_W-1:0]  bpm;
  logic              div_issued;
  logic [DIV_W-1:0]  dq;
  logic [DIV_W-1:0]  dr;

  logic [TICK_W-1:0] mop;
  logic [TICK_W-1:0] aop;
  logic [PROD_W-1:0] mul_res;
  logic [RES_W:0]    rsum;
  logic [RES_W-1:0]  r_next;
  logic [RES_W-1:0]  sc_next;
  logic [TICK_W-1:0] k_next;
  logic              res_free;
  logic              take_req;
  logic [DIV_W-4:0]  c24_y;
  logic [DIV_W+8:0]  c24_p;
  logic [DIV_W-1:0]  c24_q;
  logic [DIV_W-1:0]  c24_r;

  assign req_stall = rst || (ctrl.op != OP_ACCEPT);
  assign take_req  = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;

  always_comb begin
    case (ctrl.msel)
      M_TICKS: mop = ticks;
      M_31:    mop = SLOW_TICKS;
      M_BEST:  mop = best;
      default: mop = ticks;
    endcase
    case (ctrl.asel)
      ADD_ZERO:  aop = '0;
      ADD_TICKS: aop = ticks;
      ADD_12:    aop = ROUND_ADD;
      default:   aop = '0;
    endcase
  end

  assign mul_res = PROD_W'(qpm) * PROD_W'(mop) + PROD_W'(aop);

  always_comb begin
    case (ctrl.nsel)
      N_791:   div_num = NUM_LO;
      N_6143:  div_num = NUM_HI;
      N_PROD:  div_num = prod[DIV_W-1:0];
      N_QPM:   div_num = qpm;
      default: div_num = NUM_LO;
    endcase
  end

  // Only divisions by the tempo go to the bit-serial divider
  assign div_den   = qpm;
  assign div_start = (ctrl.op == OP_DIV) && (ctrl.dsel == D_QPM) && !div_issued;

  // Quotient and residue by 24 in one step
  assign c24_y = div_num[DIV_W-1:3];
  assign c24_p = (DIV_W+9)'(c24_y) * (DIV_W+9)'(RECIP_3);
  assign c24_q = DIV_W'(c24_p[DIV_W+8:RECIP_SH]);
  assign c24_r = div_num - c24_q * DIV_BASE;

  // Next residue of qpm*k mod 24 for the following candidate
  assign rsum    = {1'b0, r} + {1'b0, stp};
  assign r_next  = (rsum >= BASE2) ? RES_W'(rsum - BASE2) : rsum[RES_W-1:0];
  assign sc_next = score(r_next);
  assign k_next  = kcur + 1'b1;

  always_comb begin
    case (ctrl.op)
      OP_ACCEPT: stat.go = take_req;
      OP_DIV:    stat.go = (ctrl.dsel == D_24) || div_done;
      OP_EMIT:   stat.go = res_free;
      default:   stat.go = 1'b1;
    endcase
    stat.keep   = (ticks != '0) && (prod > KEEP_LO) && (prod <= KEEP_HI);
    stat.lt26   = (qpm < QPM_VSLOW);
    stat.lt33   = (qpm < QPM_SLOW_END);
    stat.ge6144 = (qpm >= QPM_FAST);
    stat.kdone  = (kcur >= last);
    stat.kmore  = (k_next < last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      div_issued <= 1'b0;
    end else begin
      if (div_start) div_issued <= 1'b1;
      else if (div_done) div_issued <= 1'b0;
      if ((ctrl.op == OP_EMIT) && res_free) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ACCEPT: begin
        if (take_req) begin
          qpm   <= quarters_per_minute;
          ticks <= current_ticks;
        end
      end
      OP_MUL: prod <= mul_res;
      OP_DIV: begin
        if (ctrl.dsel == D_24) begin
          dq <= c24_q;
          dr <= c24_r;
        end else if (div_done) begin
          dq <= div_quo;
          dr <= div_rem;
        end
      end
      OP_SET_KEEP: begin
        spd <= ticks;
        bpm <= dq[BPM_W-1:0];
      end
      OP_SET_VSLOW: begin
        spd <= SLOW_TICKS;
        bpm <= VSLOW_BPM;
      end
      OP_SET_SLOW: begin
        spd <= SLOW_TICKS;
        bpm <= dq[BPM_W-1:0];
      end
      OP_SET_FAST: begin
        spd <= FAST_TICKS;
        bpm <= FAST_BPM;
      end
      OP_INIT_BEST: begin
        best <= dq[TICK_W-1:0] + 1'b1;
        kcur <= dq[TICK_W-1:0] + 1'b1;
      end
      OP_SET_LAST: last <= dq[TICK_W-1:0];
      OP_SET_STEP: stp <= dr[RES_W-1:0];
      OP_SET_R: begin
        r   <= dr[RES_W-1:0];
        bsc <= score(dr[RES_W-1:0]);
      end
      OP_SCAN: begin
        kcur <= k_next;
        r    <= r_next;
        if (sc_next > bsc) begin
          best <= k_next;
          bsc  <= sc_next;
        end
      end
      OP_SET_SRCH: begin
        spd <= best;
        bpm <= dq[BPM_W-1:0];
      end
      OP_EMIT: begin
        if (res_free) begin
          ticks_per_division <= spd;
          beats_per_minute   <= bpm;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/tempo_to_ticks_and_bpm_top.sv
// Top level of the tempo to ticks/bpm converter.
// Depends on ttb_pkg, ttb_div, ttb_seq and ttb_dpath.
//
//   channel   signals                                         flow
//   --------  ----------------------------------------------  ---------
//   request   req_valid, req_stall,                           into block
//             quarters_per_minute[15:0], current_ticks[7:0]
//   result    res_valid, res_stall,                           out of block
//             ticks_per_division[7:0], beats_per_minute[8:0]
//
// Flow: one request at a time; the next is taken the cycle after the result loads.
// 791/qpm and 6143/qpm run on the bit-serial divider; a divide or mod by 24 is
// combinational and is registered in its own step. The search scans every
// candidate and is longest at a tempo of 33, which has the most candidates.
// Reset: rst clears the step counter, the result valid and the divider control;
// req_stall stays high while rst is held.
// Stalls: a finished result waits in the output register while res_stall is high;
// the next request is taken meanwhile and its computation runs up to the emit
// step, which holds until the output register frees.
module tempo_to_ticks_and_bpm_top
  import ttb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [QPM_W-1:0]  quarters_per_minute,
  input  logic [TICK_W-1:0] current_ticks,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [TICK_W-1:0] ticks_per_division,
  output logic [BPM_W-1:0]  beats_per_minute
);

  ctrl_t            ctrl;
  stat_t            stat;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_num;
  logic [DIV_W-1:0] div_den;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_rem;

  // Microprogram: step counter plus table
  ttb_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // Operand registers, multiplier, divide by 24, search state and output register
  ttb_dpath u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (ctrl),
    .stat                (stat),
    .req_valid           (req_valid),
    .req_stall           (req_stall),
    .quarters_per_minute (quarters_per_minute),
    .current_ticks       (current_ticks),
    .res_valid           (res_valid),
    .res_stall           (res_stall),
    .ticks_per_division  (ticks_per_division),
    .beats_per_minute    (beats_per_minute),
    .div_start           (div_start),
    .div_num             (div_num),
    .div_den             (div_den),
    .div_done            (div_done),
    .div_quo             (div_quo),
    .div_rem             (div_rem)
  );

  // Bit-serial divider for 791/qpm and 6143/qpm
  ttb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

endmodule

// File: dv/tb.sv
// Self-checking testbench for tempo_to_ticks_and_bpm_top: directed and random requests
// with gaps, result stalls, and every result checked against a local predictor.
// Depends on ttb_pkg and the RTL of tempo_to_ticks_and_bpm_top.
module tb
  import ttb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT    = 600000;  // cycles before the run is declared hung
  localparam int DRAIN_CYCLES = 300;     // longer than the slowest search
  localparam int RANDOM_COUNT = 650;
  localparam int REPORT_MAX   = 10;

  // Decision branch taken for a tempo; used for the coverage summary only
  typedef enum int {PATH_KEEP, PATH_VSLOW, PATH_SLOW, PATH_FAST, PATH_SEARCH, PATH_COUNT}
    path_t;

  typedef struct {
    logic [TICK_W-1:0] ticks;
    logic [BPM_W-1:0]  bpm;
    path_t             path;
  } tempo_choice_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  logic [QPM_W-1:0]  quarters_per_minute;
  logic [TICK_W-1:0] current_ticks;
  logic              res_valid;
  logic              res_stall;
  logic [TICK_W-1:0] ticks_per_division;
  logic [BPM_W-1:0]  beats_per_minute;

  tempo_choice_t pending_choices[$];
  int            path_hits[PATH_COUNT];
  int            requests_sent;
  int            results_checked;
  int            fail_count;
  int            cycle_count;
  bit            sender_idles;    // cleared for stretches of back-to-back requests
  bit            stall_enabled;   // cleared for stretches with the result side open

  tempo_to_ticks_and_bpm_top i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .req_valid           (req_valid),
    .req_stall           (req_stall),
    .quarters_per_minute (quarters_per_minute),
    .current_ticks       (current_ticks),
    .res_valid           (res_valid),
    .res_stall           (res_stall),
    .ticks_per_division  (ticks_per_division),
    .beats_per_minute    (beats_per_minute)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Doubled distance of qpm*k mod 24 from 12 (half a beat); larger is nearer a beat
  function automatic int unsigned beat_closeness(input int unsigned product);
    int unsigned rem;
    rem = product % 24;
    return (2 * rem >= 24) ? (2 * rem - 24) : (24 - 2 * rem);
  endfunction

  // Predict the speed/bpm pair chosen for one tempo request
  function automatic tempo_choice_t predict_tempo_choice(input logic [QPM_W-1:0] qpm_in,
                                                         input logic [TICK_W-1:0] ticks_in);
    tempo_choice_t choice;
    int unsigned   qpm;
    int unsigned   tk;
    int unsigned   best;
    int unsigned   last;
    int unsigned   best_score;
    int unsigned   cand_score;
    qpm = qpm_in;
    tk  = ticks_in;
    if (tk != 0 && (792 / tk) <= qpm && qpm + 1 <= (6144 / tk)) begin
      choice.ticks = TICK_W'(tk);
      choice.bpm   = BPM_W'((qpm * tk) / 24);
      choice.path  = PATH_KEEP;
    end else if (qpm < 26) begin
      choice.ticks = 8'd31;
      choice.bpm   = 9'd33;
      choice.path  = PATH_VSLOW;
    end else if (qpm < 33) begin
      choice.ticks = 8'd31;
      choice.bpm   = BPM_W'((qpm * 31) / 24);
      choice.path  = PATH_SLOW;
    end else if (qpm >= 6144) begin
      choice.ticks = 8'd1;
      choice.bpm   = 9'd255;
      choice.path  = PATH_FAST;
    end else begin
      // Scan candidates in ascending order; only a strictly closer one replaces the best
      best       = 791 / qpm + 1;
      last       = 6143 / qpm;
      best_score = beat_closeness(qpm * best);
      for (int unsigned k = best + 1; k <= last; k++) begin
        cand_score = beat_closeness(qpm * k);
        if (cand_score > best_score) begin
          best_score = cand_score;
          best       = k;
        end
      end
      choice.ticks = TICK_W'(best);
      choice.bpm   = BPM_W'((best * qpm + 12) / 24);
      choice.path  = PATH_SEARCH;
    end
    return choice;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    else if (roll < 90) return $urandom_range(3, 1);
    else return $urandom_range(40, 10);
  endfunction

  // Present one request at the falling edge, hold it until accepted, then queue
  // its expected result. Valid is left high so a following request can go
  // back to back; a gap lowers it at the next falling edge.
  task automatic send_tempo_request(input logic [QPM_W-1:0] qpm,
                                    input logic [TICK_W-1:0] ticks);
    tempo_choice_t choice;
    int unsigned   gap;
    gap = sender_idles ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid           <= 1'b1;
    quarters_per_minute <= qpm;
    current_ticks       <= ticks;
    do @(posedge clk); while (req_stall);
    choice = predict_tempo_choice(qpm, ticks);
    pending_choices.push_back(choice);
    path_hits[choice.path]++;
    requests_sent++;
  endtask

  // Result side: hold stall for random stretches, with spells of no stall at all
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(199) == 0) stall_enabled = ~stall_enabled;
      if (stall_left > 0) begin
        stall_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        if (stall_enabled && $urandom_range(2) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted result with the oldest waiting expectation
  always @(posedge clk) begin
    tempo_choice_t exp_choice;
    if (!rst && res_valid && !res_stall) begin
      if (pending_choices.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("[%0t] unexpected result: ticks=%0d bpm=%0d", $time,
                   ticks_per_division, beats_per_minute);
      end else begin
        exp_choice = pending_choices.pop_front();
        results_checked++;
        if (ticks_per_division !== exp_choice.ticks || beats_per_minute !== exp_choice.bpm)
        begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("[%0t] mismatch: ticks exp %0d got %0d, bpm exp %0d got %0d",
                     $time, exp_choice.ticks, ticks_per_division,
                     exp_choice.bpm, beats_per_minute);
        end
      end
    end
  end

  // Very slow, slow and very fast fixed answers, at their edges
  task automatic test_fixed_ranges();
    send_tempo_request(16'd0, 8'd255);
    send_tempo_request(16'd25, 8'd255);
    send_tempo_request(16'd24, 8'd255);
    send_tempo_request(16'd26, 8'd255);
    send_tempo_request(16'd32, 8'd200);
    send_tempo_request(16'd6144, 8'd1);
    send_tempo_request(16'hFFFF, 8'd255);
  endtask

  // Keep the current ticks at both ends of their usable range
  task automatic test_keep_ticks();
    send_tempo_request(16'd792, 8'd1);
    send_tempo_request(16'd6143, 8'd1);
    send_tempo_request(16'd3, 8'd255);
    send_tempo_request(16'd23, 8'd255);
    send_tempo_request(16'd33, 8'd24);
    send_tempo_request(16'd255, 8'd24);
  endtask

  // Search: the slowest tempo, a single candidate, and ranges just outside keep
  task automatic test_search();
    send_tempo_request(16'd33, 8'd1);
    send_tempo_request(16'd791, 8'd1);
    send_tempo_request(16'd256, 8'd24);
    send_tempo_request(16'd6143, 8'd2);
    send_tempo_request(16'd4000, 8'd3);
    send_tempo_request(16'd100, 8'd100);
    send_tempo_request(16'd1000, 8'd7);
  endtask

  // Ticks of zero never keep; the other branches decide
  task automatic test_zero_ticks();
    send_tempo_request(16'd0, 8'd0);
    send_tempo_request(16'd30, 8'd0);
    send_tempo_request(16'd1000, 8'd0);
    send_tempo_request(16'd7000, 8'd0);
  endtask

  // Random tempi weighted toward the search and keep branches
  task automatic test_random_mix(input int count);
    logic [QPM_W-1:0]  qpm;
    logic [TICK_W-1:0] ticks;
    int unsigned       roll;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) sender_idles = ($urandom_range(3) != 0);
      ticks = TICK_W'(($urandom_range(3) == 0) ? $urandom_range(12, 1)
                                               : $urandom_range(255, 1));
      roll  = $urandom_range(99);
      if (roll < 8)       qpm = QPM_W'($urandom_range(25, 0));
      else if (roll < 16) qpm = QPM_W'($urandom_range(32, 26));
      else if (roll < 26) qpm = QPM_W'($urandom_range(65535, 6144));
      else if (roll < 50) qpm = QPM_W'($urandom_range(6144 / ticks - 1, 792 / ticks));
      else if (roll < 60) qpm = QPM_W'($urandom_range(200, 33));
      else                qpm = QPM_W'($urandom_range(6143, 33));
      send_tempo_request(qpm, ticks);
    end
  endtask

  // Hung-run guard: fail if the run has not finished within the limit
  initial begin
    while (cycle_count < RUN_LIMIT) @(posedge clk);
    $display("tempo_to_ticks_and_bpm_top regression: fail");
    $finish;
  end

  initial begin
    cycle_count         = 0;
    fail_count          = 0;
    requests_sent       = 0;
    results_checked     = 0;
    sender_idles        = 1'b1;
    stall_enabled       = 1'b1;
    rst                 = 1'b1;
    req_valid           = 1'b0;
    res_stall           = 1'b0;
    quarters_per_minute = '0;
    current_ticks       = '0;
    foreach (path_hits[p]) path_hits[p] = 0;

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fixed_ranges();
    test_keep_ticks();
    test_search();
    test_zero_ticks();
    test_random_mix(RANDOM_COUNT);
    @(negedge clk);
    req_valid <= 1'b0;

    // Drain: wait for every expected result, then watch for strays
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_choices.size() != 0) fail_count++;

    $display("Covered %0d tempo requests, %0d results checked, %0d failures.",
             requests_sent, results_checked, fail_count);
    $display("Branches: keep %0d, very slow %0d, slow %0d, very fast %0d, search %0d.",
             path_hits[PATH_KEEP], path_hits[PATH_VSLOW], path_hits[PATH_SLOW],
             path_hits[PATH_FAST], path_hits[PATH_SEARCH]);
    if (fail_count == 0) $display("tempo_to_ticks_and_bpm_top regression: pass");
    else $display("tempo_to_ticks_and_bpm_top regression: fail");
    $finish;
  end

endmodule

// File: sim.f
rtl/ttb_pkg.sv
rtl/ttb_div.sv
rtl/ttb_seq.sv
rtl/ttb_dpath.sv
rtl/tempo_to_ticks_and_bpm_top.sv
dv/tb.sv
